// ===== sv/ap_pkg.sv =====
// shared constants and types of the armenteros-podolanski block
package ap_pkg;

  // qt result width, fixed by the output format
  localparam int QT_BITS = 23;

  // side information that travels with each request
  typedef struct packed {
    logic vld;
    logic res_ok;
    logic a_ovf;
    logic dneg;
  } ap_flags_t;

endpackage

// ===== sv/ap_shift.sv =====
// enable-gated delay line
module ap_shift #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] r [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) r[i] <= '0;
    end else if (en) begin
      r[0] <= d;
      for (int i = 1; i < DEPTH; i++) r[i] <= r[i-1];
    end
  end

  assign q = r[DEPTH-1];

endmodule

// ===== sv/ap_front.sv =====
// products, cross product, squared magnitudes and dividends
module ap_front #(
  parameter int W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [W-1:0]    pos_px,
  input  logic signed [W-1:0]    pos_py,
  input  logic signed [W-1:0]    pos_pz,
  input  logic signed [W-1:0]    neg_px,
  input  logic signed [W-1:0]    neg_py,
  input  logic signed [W-1:0]    neg_pz,
  output logic [4*W+1:0]         c2,
  output logic [2*W+1:0]         s2,
  output logic [2*W-1:0]         dmag,
  output ap_pkg::ap_flags_t      flags
);

  import ap_pkg::*;

  localparam int IA [3] = '{1, 2, 0};
  localparam int IB [3] = '{2, 0, 1};
  localparam int K = W + 1;

  logic signed [W-1:0]   pin [3];
  logic signed [W-1:0]   nin [3];
  logic signed [W:0]     s_c [3];
  logic                  ok_c;

  // stage 1
  logic signed [W-1:0]   p1 [3];
  logic signed [W-1:0]   n1 [3];
  logic signed [W:0]     s1 [3];
  // stage 2
  logic signed [2*W:0]   ma_c [3];
  logic signed [2*W:0]   mb_c [3];
  logic signed [2*W+1:0] ss_c [3];
  logic signed [2*W-1:0] pp_c [3];
  logic signed [2*W-1:0] nn_c [3];
  logic signed [2*W:0]   ma2 [3];
  logic signed [2*W:0]   mb2 [3];
  logic [2*W:0]          ss2 [3];
  logic [2*W-2:0]        pp2 [3];
  logic [2*W-2:0]        nn2 [3];
  // stage 3
  logic signed [2*W+1:0] cr3 [3];
  logic [2*W+1:0]        s2_3;
  logic [2*W-1:0]        pps3;
  logic [2*W-1:0]        nns3;
  // stage 4
  logic [2*W:0]          cab4 [3];
  logic signed [2*W:0]   d4;
  logic [2*W+1:0]        s2_4;
  // stage 5
  logic [2*W-1:0]        hh5 [3];
  logic [2*W:0]          hl5 [3];
  logic [2*W+1:0]        ll5 [3];
  logic [2*W-1:0]        dmag5;
  logic [2*W+1:0]        s2_5;
  // stage 6
  logic [4*W:0]          sq6 [3];
  logic [2*W-1:0]        dmag6;
  logic [2*W+1:0]        s2_6;
  logic                  aovf_c;
  // stage 7
  logic [4*W+1:0]        c2_7;
  logic [2*W-1:0]        dmag7;
  logic [2*W+1:0]        s2_7;

  ap_flags_t fl [7];
  ap_flags_t f4_c;
  ap_flags_t f5_c;

  always_comb begin
    pin[0] = pos_px; pin[1] = pos_py; pin[2] = pos_pz;
    nin[0] = neg_px; nin[1] = neg_py; nin[2] = neg_pz;
    for (int i = 0; i < 3; i++) s_c[i] = (W+1)'(pin[i]) + (W+1)'(nin[i]);
    ok_c = (s_c[0] != '0 || s_c[1] != '0 || s_c[2] != '0) &&
           (nin[0] != '0 || nin[1] != '0 || nin[2] != '0);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma_c[k] = (2*W+1)'(n1[IA[k]]) * (2*W+1)'(s1[IB[k]]);
      mb_c[k] = (2*W+1)'(n1[IB[k]]) * (2*W+1)'(s1[IA[k]]);
      ss_c[k] = (2*W+2)'(s1[k]) * (2*W+2)'(s1[k]);
      pp_c[k] = (2*W)'(p1[k]) * (2*W)'(p1[k]);
      nn_c[k] = (2*W)'(n1[k]) * (2*W)'(n1[k]);
    end
  end

  always_comb begin
    f4_c = fl[3];
    f4_c.dneg = d4[2*W];
    f5_c = fl[4];
    aovf_c = {2'b00, dmag5[2*W-1:2]} >= s2_5;
    f5_c.a_ovf = aovf_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= pin[i];
        n1[i] <= nin[i];
        s1[i] <= s_c[i];
        ma2[i] <= ma_c[i];
        mb2[i] <= mb_c[i];
        ss2[i] <= ss_c[i][2*W:0];
        pp2[i] <= pp_c[i][2*W-2:0];
        nn2[i] <= nn_c[i][2*W-2:0];
        cr3[i] <= (2*W+2)'(ma2[i]) - (2*W+2)'(mb2[i]);
        cab4[i] <= cr3[i][2*W+1] ? (2*W+1)'(-cr3[i]) : (2*W+1)'(cr3[i]);
        // split into high and low halves to keep multipliers narrow
        hh5[i] <= (2*W)'(cab4[i][2*W:K]) * (2*W)'(cab4[i][2*W:K]);
        hl5[i] <= (2*W+1)'(cab4[i][2*W:K]) * (2*W+1)'(cab4[i][K-1:0]);
        ll5[i] <= (2*W+2)'(cab4[i][K-1:0]) * (2*W+2)'(cab4[i][K-1:0]);
        sq6[i] <= ((4*W+1)'(hh5[i]) << (2*K)) + ((4*W+1)'(hl5[i]) << (K+1))
                  + (4*W+1)'(ll5[i]);
      end
      s2_3  <= (2*W+2)'(ss2[0]) + (2*W+2)'(ss2[1]) + (2*W+2)'(ss2[2]);
      pps3  <= (2*W)'(pp2[0]) + (2*W)'(pp2[1]) + (2*W)'(pp2[2]);
      nns3  <= (2*W)'(nn2[0]) + (2*W)'(nn2[1]) + (2*W)'(nn2[2]);
      d4    <= $signed({1'b0, pps3}) - $signed({1'b0, nns3});
      s2_4  <= s2_3;
      dmag5 <= d4[2*W] ? (2*W)'(-d4) : (2*W)'(d4);
      s2_5  <= s2_4;
      dmag6 <= dmag5;
      s2_6  <= s2_5;
      c2_7  <= (4*W+2)'(sq6[0]) + (4*W+2)'(sq6[1]) + (4*W+2)'(sq6[2]);
      dmag7 <= dmag6;
      s2_7  <= s2_6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 7; j++) fl[j] <= '0;
    end else if (en) begin
      fl[0] <= '{vld: in_vld, res_ok: ok_c, a_ovf: 1'b0, dneg: 1'b0};
      fl[1] <= fl[0];
      fl[2] <= fl[1];
      fl[3] <= fl[2];
      fl[4] <= f4_c;
      fl[5] <= f5_c;
      fl[6] <= fl[5];
    end
  end

  assign c2    = c2_7;
  assign s2    = s2_7;
  assign dmag  = dmag7;
  assign flags = fl[6];

endmodule

// ===== sv/ap_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ap_div #(
  parameter int DVW = 50,
  parameter int QB  = 48
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] rem_in,
  input  logic [QB-1:0]  low_in,
  input  logic [DVW-1:0] dv_in,
  output logic [QB-1:0]  quo
);

  logic [DVW-1:0] rem_s [QB+1];
  logic [QB-1:0]  low_s [QB+1];
  logic [DVW-1:0] dv_s  [QB+1];
  logic [QB-1:0]  q_s   [QB+1];

  assign rem_s[0] = rem_in;
  assign low_s[0] = low_in;
  assign dv_s[0]  = dv_in;
  assign q_s[0]   = '0;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DVW:0] t;
    logic [DVW:0] diff;
    logic         ge;

    always_comb begin
      t    = {rem_s[g], low_s[g][QB-1]};
      diff = t - {1'b0, dv_s[g]};
      ge   = t >= {1'b0, dv_s[g]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= ge ? diff[DVW-1:0] : t[DVW-1:0];
        low_s[g+1] <= low_s[g] << 1;
        dv_s[g+1]  <= dv_s[g];
        q_s[g+1]   <= {q_s[g][QB-2:0], ge};
      end
    end
  end

  assign quo = q_s[QB];

endmodule

// ===== sv/ap_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module ap_isqrt #(
  parameter int RW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [2*RW-1:0] x_in,
  output logic [RW-1:0] root
);

  logic [RW:0]     rem_s  [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [2*RW-1:0] x_s    [RW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = x_in;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    always_comb begin
      t     = {rem_s[g], x_s[g][2*RW-1:2*RW-2]};
      trial = {1'b0, root_s[g], 2'b01};
      diff  = t - trial;
      ge    = t >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= ge ? diff[RW:0] : t[RW:0];
        root_s[g+1] <= {root_s[g][RW-2:0], ge};
        x_s[g+1]    <= x_s[g] << 2;
      end
    end
  end

  assign root = root_s[RW];

endmodule

// ===== sv/armenteros_podolanski_variables.sv =====
// armenteros-podolanski qt and alpha, one momentum pair per clock unless the output stalls
// throughput: one request per cycle; a stalled output freezes the whole pipeline
// the front end, the qt divider (one bit per stage) and the square root stages set the depth
// rst is synchronous: it clears all valid bits, nothing is lost but in-flight requests
module armenteros_podolanski_variables #(
  parameter int MOM_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_px, pos_py, pos_pz, neg_px, neg_py, neg_pz from bit 0 up, zero padded
  input  logic [((6*MOM_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // qt, alpha from bit 0 up, zero padded
  output logic [((ap_pkg::QT_BITS+FRAC_BITS+3+7)/8)*8-1:0] m_tdata,
  // result_valid, saturated from bit 0 up
  output logic [1:0] m_tuser
);

  import ap_pkg::*;

  localparam int W      = MOM_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int QW     = 2 * W;
  localparam int S2W    = 2 * W + 2;
  localparam int C2W    = 4 * W + 2;
  localparam int AW     = F + 3;
  localparam int OUT_TW = ((QT_BITS + AW + 7) / 8) * 8;
  localparam int DLY    = QW + QT_BITS;
  localparam int ADLY   = DLY - (F + 2);
  localparam int QXW    = (QW > 2 * QT_BITS) ? QW : 2 * QT_BITS;
  localparam logic [F+1:0]   ALIM = {1'b1, {(F+1){1'b0}}};
  localparam logic [AW-1:0]  AMAX = {1'b0, ALIM};

  logic             en;
  logic [C2W-1:0]   c2;
  logic [S2W-1:0]   s2;
  logic [2*W-1:0]   dmag;
  ap_flags_t        flags;
  ap_flags_t        fl_d;
  logic [QW-1:0]    qq;
  logic [QXW-1:0]   q_ext;
  logic             qovf;
  logic             qovf_d;
  logic [QT_BITS-1:0] root;
  logic [F+1:0]     aq;
  logic [F+1:0]     aq_d;

  logic             a_big;
  logic [F+1:0]     mag;
  logic [AW-1:0]    alpha_c;
  logic [QT_BITS-1:0] qt_c;
  logic             sat_c;

  logic [QT_BITS-1:0] qt_r;
  logic [AW-1:0]    alpha_r;
  logic             ok_r;
  logic             sat_r;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ap_front #(.W(W)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid),
    .pos_px (s_tdata[0*W +: W]),
    .pos_py (s_tdata[1*W +: W]),
    .pos_pz (s_tdata[2*W +: W]),
    .neg_px (s_tdata[3*W +: W]),
    .neg_py (s_tdata[4*W +: W]),
    .neg_pz (s_tdata[5*W +: W]),
    .c2     (c2),
    .s2     (s2),
    .dmag   (dmag),
    .flags  (flags)
  );

  // |NxS|^2 / |S|^2; the top part of the dividend is already below the divisor
  ap_div #(.DVW(S2W), .QB(QW)) u_qt_div (
    .clk    (clk),
    .en     (en),
    .rem_in (c2[C2W-1:QW]),
    .low_in (c2[QW-1:0]),
    .dv_in  (s2),
    .quo    (qq)
  );

  // |d| * 2^F / |S|^2, overflow beyond F+2 quotient bits flagged up front
  ap_div #(.DVW(S2W), .QB(F+2)) u_alpha_div (
    .clk    (clk),
    .en     (en),
    .rem_in ({4'b0000, dmag[2*W-1:2]}),
    .low_in ({dmag[1:0], {F{1'b0}}}),
    .dv_in  (s2),
    .quo    (aq)
  );

  assign q_ext = QXW'(qq);
  assign qovf  = |(q_ext >> (2 * QT_BITS));

  ap_isqrt #(.RW(QT_BITS)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .x_in (q_ext[2*QT_BITS-1:0]),
    .root (root)
  );

  ap_shift #(.WIDTH(1), .DEPTH(QT_BITS)) u_qovf_dly (
    .clk (clk), .rst (rst), .en (en), .d (qovf), .q (qovf_d)
  );

  ap_shift #(.WIDTH(F+2), .DEPTH(ADLY)) u_alpha_dly (
    .clk (clk), .rst (rst), .en (en), .d (aq), .q (aq_d)
  );

  ap_shift #(.WIDTH($bits(ap_flags_t)), .DEPTH(DLY)) u_flag_dly (
    .clk (clk), .rst (rst), .en (en), .d (flags), .q (fl_d)
  );

  always_comb begin
    a_big   = fl_d.a_ovf || (aq_d > ALIM);
    mag     = a_big ? ALIM : aq_d;
    alpha_c = fl_d.dneg ? (AW'(0) - {1'b0, mag}) : {1'b0, mag};
    qt_c    = qovf_d ? '1 : root;
    sat_c   = a_big || qovf_d;
    if (!fl_d.res_ok) begin
      alpha_c = '0;
      qt_c    = '0;
      sat_c   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fl_d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qt_r    <= qt_c;
      alpha_r <= alpha_c;
      ok_r    <= fl_d.res_ok;
      sat_r   <= sat_c;
    end
  end

  assign m_tdata = OUT_TW'({alpha_r, qt_r});
  assign m_tuser = {sat_r, ok_r};

  // an invalid pair carries all-zero fields
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !ok_r |-> qt_r == '0 && alpha_r == '0 && !sat_r)
    else $error("invalid result with nonzero fields");

  // alpha never leaves plus or minus two
  a_alpha_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(alpha_r) <= $signed(AMAX) &&
                 $signed(alpha_r) >= -$signed(AMAX))
    else $error("alpha out of range");

  // saturation without a clipped qt means alpha was clipped to two
  a_sat_alpha : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && sat_r && qt_r != '1 |-> alpha_r == AMAX || alpha_r == -AMAX)
    else $error("saturation flag without clipped field");

  // saturation implies a valid result
  a_sat_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && sat_r |-> ok_r)
    else $error("saturation on invalid result");

  a_reset_idle : assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule
